/* hdl/trpq_pkg.sv */
// Shared types and constants for the timed release packet queue.
`default_nettype none

package trpq_pkg;

  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int QS_W          = 11;
  localparam int DELAY_W       = 16;
  localparam int LIMIT_W       = 36;
  localparam int TOTAL_W       = 48;
  localparam int QCOUNT_W      = 10;
  localparam int BITS_W        = 20;
  localparam int NS_PER_MS     = 1000000;
  localparam int WIRE_OVERHEAD = 24;

  localparam logic [QS_W-1:0] HIGH_WATER_RESET = 11'd921;
  localparam logic [QS_W-1:0] LOW_WATER_RESET  = 11'd153;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_POLL    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_DELAY      = 3'd0,
    REG_QSIZE      = 3'd1,
    REG_BP_EN      = 3'd2,
    REG_HIGH_WATER = 3'd3,
    REG_LOW_WATER  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic         operation;
    logic [31:0]  packet_handle;
    logic [63:0]  packet_stamp_ns;
    logic [15:0]  packet_length;
    logic [63:0]  now_ns;
    logic         downstream_overloaded;
  } item_t;

  typedef struct packed {
    logic                released_valid;
    logic [31:0]         released_handle;
    logic [15:0]         released_length;
    logic [BITS_W-1:0]   released_bits;
    logic                enqueue_accepted;
    logic                overload_signal;
    logic                underload_signal;
    logic [QCOUNT_W-1:0] queue_count;
    logic [TOTAL_W-1:0]  enqueued_total;
    logic [TOTAL_W-1:0]  dequeued_total;
    logic [TOTAL_W-1:0]  dropped_total;
  } result_t;

  // one ring slot as stored in memory
  typedef struct packed {
    logic [31:0] handle;
    logic [63:0] stamp;
    logic [15:0] length;
  } slot_t;

  // configuration as seen by the ring control
  typedef struct packed {
    logic [LIMIT_W-1:0] limit_ns;
    logic [QS_W-1:0]    queue_size;
    logic               bp_enable;
    logic [QS_W-1:0]    high_water;
    logic [QS_W-1:0]    low_water;
    logic               ring_clear;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/trpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/trpq_cfg.sv */
// APB register file: delay, ring size, backpressure enable and water marks.
`default_nettype none

module trpq_cfg import trpq_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  localparam int QS_RESET = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  logic [DELAY_W-1:0] delay_ms;
  logic [QS_W-1:0]    qs_wdata;
  logic               qs_ok;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign idx      = reg_idx_t'(paddr[4:2]);
  assign qs_wdata = pwdata[QS_W-1:0];
  assign qs_ok    = (qs_wdata >= QS_W'(4)) && ({21'b0, qs_wdata} <= 32'(MAX_SLOTS)) &&
                    ((qs_wdata & (qs_wdata - QS_W'(1))) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms       <= '0;
      cfg.limit_ns   <= '0;
      cfg.queue_size <= QS_W'(QS_RESET);
      cfg.bp_enable  <= 1'b0;
      cfg.high_water <= HIGH_WATER_RESET;
      cfg.low_water  <= LOW_WATER_RESET;
      cfg.ring_clear <= 1'b0;
    end else begin
      cfg.ring_clear <= 1'b0;
      if (wr_en) begin
        case (idx)
          REG_DELAY: begin
            delay_ms     <= pwdata[DELAY_W-1:0];
            // threshold in ns kept ready so the poll needs no multiply
            cfg.limit_ns <= LIMIT_W'(pwdata[DELAY_W-1:0]) * LIMIT_W'(NS_PER_MS);
          end
          REG_QSIZE: begin
            if (qs_ok) begin
              cfg.queue_size <= qs_wdata;
              cfg.ring_clear <= 1'b1;
            end
          end
          REG_BP_EN:      cfg.bp_enable  <= pwdata[0];
          REG_HIGH_WATER: cfg.high_water <= pwdata[QS_W-1:0];
          REG_LOW_WATER:  cfg.low_water  <= pwdata[QS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DELAY:      prdata = DATA_W'(delay_ms);
      REG_QSIZE:      prdata = DATA_W'(cfg.queue_size);
      REG_BP_EN:      prdata = DATA_W'(cfg.bp_enable);
      REG_HIGH_WATER: prdata = DATA_W'(cfg.high_water);
      REG_LOW_WATER:  prdata = DATA_W'(cfg.low_water);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/timed_release_packet_queue.sv */
// Top level: ring control, held head, release decision and result register.
// Timed release packet queue. Packet descriptors live in one ring memory
// (handle, stamp, length) indexed by read and write pointers; the oldest one
// is moved into a head register and released by a poll once now_ns minus its
// stamp reaches delay_ms * 1e6 ns. One item is worked on at a time. For an
// enqueue, or a poll that does not pull a new head out of the ring, the item
// goes from S_IDLE to S_EXEC, where the result register loads once it is free,
// and item_ready stays low until the state is back in S_IDLE. A poll that must
// first pull the head out of the ring passes through S_LOAD in between, to
// take the memory's registered read data into the head. The finished
// result sits in an output register, so the next item is taken while it
// waits; a result is only held back when that register is still occupied. A
// memory write and a read of the same slot never fall in the same cycle,
// since every access comes from a different step of the sequence. Writing a
// valid ring size raises a registered ring_clear strobe that empties the
// ring; there is no clearing pass.
`default_nettype none

module timed_release_packet_queue import trpq_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CMP_W = ((IDX_W > QS_W) ? IDX_W : QS_W) + 1;

  cfg_t cfg;

  trpq_cfg #(.MAX_SLOTS(MAX_SLOTS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t state, state_next;
  item_t  cur;
  logic   accept;

  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [IDX_W-1:0]   wr_idx, wr_idx_next;
  logic [IDX_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   qmask;
  logic               head_held, head_held_next;
  slot_t              head;
  logic [TOTAL_W-1:0] enq_total, enq_total_next;
  logic [TOTAL_W-1:0] deq_total, deq_total_next;
  logic [TOTAL_W-1:0] drop_total, drop_total_next;
  result_t            result_next;
  logic               result_load;
  logic               out_free;
  logic               has_room;
  logic               release_ok;
  logic [63:0]        elapsed;
  logic [16:0]        wire_len;

  logic             ram_we, ram_re;
  slot_t            ram_wdata, ram_rdata;

  trpq_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_SLOTS)) u_ram (
    .clk,
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign qmask      = IDX_W'(cfg.queue_size - QS_W'(1));
  assign has_room   = CMP_W'(count) < (CMP_W'(cfg.queue_size) - CMP_W'(1));
  assign elapsed    = cur.now_ns - head.stamp;
  assign release_ok = head_held && ({28'b0, cfg.limit_ns} <= elapsed);
  assign wire_len   = 17'(head.length) + 17'(WIRE_OVERHEAD);

  assign ram_wdata.handle = cur.packet_handle;
  assign ram_wdata.stamp  = cur.packet_stamp_ns;
  assign ram_wdata.length = cur.packet_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    rd_idx_next     = rd_idx;
    wr_idx_next     = wr_idx;
    count_next      = count;
    head_held_next  = head_held;
    enq_total_next  = enq_total;
    deq_total_next  = deq_total;
    drop_total_next = drop_total;
    result_load     = 1'b0;
    result_next     = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          // poll with an empty head pulls the oldest slot out of memory first
          if (item.operation == OP_POLL && !item.downstream_overloaded &&
              !head_held && count != '0) begin
            ram_re     = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_LOAD: begin
        head_held_next = 1'b1;
        rd_idx_next    = (rd_idx + IDX_W'(1)) & qmask;
        count_next     = count - IDX_W'(1);
        state_next     = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
          if (cur.operation == OP_ENQUEUE) begin
            if (has_room) begin
              ram_we         = 1'b1;
              wr_idx_next    = (wr_idx + IDX_W'(1)) & qmask;
              count_next     = count + IDX_W'(1);
              enq_total_next = enq_total + TOTAL_W'(1);
              result_next.enqueue_accepted = 1'b1;
            end else begin
              drop_total_next = drop_total + TOTAL_W'(1);
            end
            result_next.overload_signal = cfg.bp_enable &&
                (CMP_W'(count_next) > CMP_W'(cfg.high_water));
          end else if (!cur.downstream_overloaded && release_ok) begin
            head_held_next              = 1'b0;
            deq_total_next              = deq_total + TOTAL_W'(1);
            result_next.released_valid  = 1'b1;
            result_next.released_handle = head.handle;
            result_next.released_length = head.length;
            result_next.released_bits   = {wire_len, 3'b000};
            result_next.underload_signal = cfg.bp_enable &&
                (CMP_W'(count) < CMP_W'(cfg.low_water));
          end
          result_next.queue_count    = QCOUNT_W'(count_next);
          result_next.enqueued_total = enq_total_next;
          result_next.dequeued_total = deq_total_next;
          result_next.dropped_total  = drop_total_next;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cfg.ring_clear) begin
      rd_idx_next = '0;
      wr_idx_next = '0;
      count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx       <= '0;
      wr_idx       <= '0;
      count        <= '0;
      head_held    <= 1'b0;
      enq_total    <= '0;
      deq_total    <= '0;
      drop_total   <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_idx     <= rd_idx_next;
      wr_idx     <= wr_idx_next;
      count      <= count_next;
      head_held  <= head_held_next;
      enq_total  <= enq_total_next;
      deq_total  <= deq_total_next;
      drop_total <= drop_total_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == S_LOAD) begin
      head <= ram_rdata;
    end
    if (result_load) begin
      result <= result_next;
    end
  end

  // ring never holds more than queue_size - 1 entries; a new size applies
  // while ring_clear is high, before the pointers are cleared
  assert property (@(posedge clk) disable iff (rst)
    cfg.ring_clear || (CMP_W'(count) < CMP_W'(cfg.queue_size)))
    else $error("ring count exceeds capacity");

  // pointers and count agree
  assert property (@(posedge clk) disable iff (rst)
    cfg.ring_clear || (((rd_idx + count) & qmask) == wr_idx))
    else $error("ring pointers out of step with count");

  // memory is never written and read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ring memory write and read collide");

  // a head load only happens into an empty head
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !head_held && count != '0)
    else $error("head load over a held packet or from an empty ring");

  // a new result is only produced by the execute step
  assert property (@(posedge clk) disable iff (rst)
    result_load |-> state == S_EXEC && out_free)
    else $error("result loaded outside execute step");

endmodule

`default_nettype wire

/* sim/trpq_checker.sv */
// Result checker for the timed release packet queue: tracks the queue and compares results.
`timescale 1ns / 1ps

module trpq_checker import trpq_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_ready,
  input  wire item_t             item,
  input  wire logic              result_valid,
  input  wire logic              result_ready,
  input  wire result_t           result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output int                     mismatches,
  output int                     in_flight
);

  localparam int PTR_W = $clog2(MAX_SLOTS);

  logic [31:0]        ring_handle [MAX_SLOTS];
  logic [63:0]        ring_stamp  [MAX_SLOTS];
  logic [15:0]        ring_len    [MAX_SLOTS];
  logic [PTR_W-1:0]   rd_ptr, wr_ptr;
  int                 fill;
  bit                 head_full;
  logic [31:0]        head_handle;
  logic [63:0]        head_stamp;
  logic [15:0]        head_len;
  logic [TOTAL_W-1:0] n_enq, n_deq, n_drop;

  logic [DELAY_W-1:0] hold_ms;
  logic [QS_W-1:0]    ring_size;
  bit                 bp_on;
  logic [QS_W-1:0]    high_mark, low_mark;

  result_t outcome_q [$];

  task automatic apply_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    logic [QS_W-1:0] v;
    v = data[QS_W-1:0];
    case (idx)
      REG_DELAY:      hold_ms = data[DELAY_W-1:0];
      REG_QSIZE: begin
        // only a power of two in range takes effect; it empties the ring, keeps the head
        if (v >= 4 && v <= MAX_SLOTS && (v & (v - 1'b1)) == '0) begin
          ring_size = v;
          rd_ptr = '0;
          wr_ptr = '0;
          fill = 0;
        end
      end
      REG_BP_EN:      bp_on = data[0];
      REG_HIGH_WATER: high_mark = v;
      REG_LOW_WATER:  low_mark = v;
      default: ;
    endcase
  endtask

  function automatic result_t service_item(input item_t it);
    result_t          r;
    logic [PTR_W-1:0] mask;
    logic [PTR_W-1:0] slot;
    logic [63:0]      elapsed;
    r = '0;
    mask = PTR_W'(ring_size - 1'b1);
    if (op_t'(it.operation) == OP_ENQUEUE) begin
      if (fill < int'(ring_size) - 1) begin
        slot = wr_ptr & mask;
        ring_handle[slot] = it.packet_handle;
        ring_stamp[slot] = it.packet_stamp_ns;
        ring_len[slot] = it.packet_length;
        wr_ptr = (slot + 1'b1) & mask;
        fill++;
        n_enq = n_enq + 1'b1;
        r.enqueue_accepted = 1'b1;
      end else begin
        n_drop = n_drop + 1'b1;
      end
      // overload test runs on drops too
      if (bp_on && fill > int'(high_mark)) r.overload_signal = 1'b1;
    end else if (!it.downstream_overloaded) begin
      if (!head_full && fill > 0) begin
        slot = rd_ptr & mask;
        head_handle = ring_handle[slot];
        head_stamp = ring_stamp[slot];
        head_len = ring_len[slot];
        head_full = 1'b1;
        rd_ptr = (slot + 1'b1) & mask;
        fill--;
      end
      if (head_full) begin
        elapsed = it.now_ns - head_stamp;  // wraps mod 2^64
        if (elapsed >= 64'(hold_ms) * 64'(NS_PER_MS)) begin
          r.released_valid = 1'b1;
          r.released_handle = head_handle;
          r.released_length = head_len;
          r.released_bits = BITS_W'((32'(head_len) + WIRE_OVERHEAD) * 8);
          head_full = 1'b0;
          n_deq = n_deq + 1'b1;
          if (bp_on && fill < int'(low_mark)) r.underload_signal = 1'b1;
        end
      end
    end
    r.queue_count = QCOUNT_W'(fill);
    r.enqueued_total = n_enq;
    r.dequeued_total = n_deq;
    r.dropped_total = n_drop;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mismatches = 0;
      outcome_q.delete();
      rd_ptr = '0;
      wr_ptr = '0;
      fill = 0;
      head_full = 1'b0;
      head_handle = '0;
      head_stamp = '0;
      head_len = '0;
      n_enq = '0;
      n_deq = '0;
      n_drop = '0;
      hold_ms = '0;
      ring_size = QS_W'(MAX_SLOTS);
      bp_on = 1'b0;
      high_mark = HIGH_WATER_RESET;
      low_mark = LOW_WATER_RESET;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr[ADDR_W-1:2], pwdata);
      if (item_valid && item_ready) outcome_q.push_back(service_item(item));
      if (result_valid && result_ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, got %0h", $time, result);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("released_valid", want.released_valid, result.released_valid);
          compare_field("released_handle", want.released_handle, result.released_handle);
          compare_field("released_length", want.released_length, result.released_length);
          compare_field("released_bits", want.released_bits, result.released_bits);
          compare_field("enqueue_accepted", want.enqueue_accepted, result.enqueue_accepted);
          compare_field("overload_signal", want.overload_signal, result.overload_signal);
          compare_field("underload_signal", want.underload_signal, result.underload_signal);
          compare_field("queue_count", want.queue_count, result.queue_count);
          compare_field("enqueued_total", want.enqueued_total, result.enqueued_total);
          compare_field("dequeued_total", want.dequeued_total, result.dequeued_total);
          compare_field("dropped_total", want.dropped_total, result.dropped_total);
        end
      end
    end
    in_flight <= outcome_q.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the timed release packet queue: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb;
  import trpq_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int errors;
  int in_flight;
  bit tx_quiet = 1'b0;

  always #5 clk = ~clk;

  timed_release_packet_queue dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  trpq_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(errors), .in_flight(in_flight)
  );

  function automatic item_t enq(input logic [31:0] h, input logic [63:0] s,
                                input logic [15:0] l);
    item_t it;
    it.operation = OP_ENQUEUE;
    it.packet_handle = h;
    it.packet_stamp_ns = s;
    it.packet_length = l;
    it.now_ns = {$urandom, $urandom};
    it.downstream_overloaded = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t poll(input logic [63:0] now, input logic down);
    item_t it;
    it.operation = OP_POLL;
    it.packet_handle = $urandom;
    it.packet_stamp_ns = {$urandom, $urandom};
    it.packet_length = 16'($urandom);
    it.now_ns = now;
    it.downstream_overloaded = down;
    return it;
  endfunction

  // called at a clock edge; returns at the edge where the transaction completes
  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, quiet stretches, and two long hold-offs
  initial begin
    int  gap;
    int  served;
    bit  quiet;
    served = 0;
    quiet = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (served == 200 || served == 600) begin
        result_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      served++;
    end
  end

  initial begin
    logic [63:0]        t0, lim, clock_ns, now, stamp, step;
    logic [DELAY_W-1:0] dly;
    logic [QS_W-1:0]    qs;
    int                 enq_pct, pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no delay, full ring size, no backpressure
    send_item(poll({$urandom, $urandom}, 1'b0));
    send_item(poll({$urandom, $urandom}, 1'b1));
    send_item(enq('1, '1, '1));
    send_item(enq('0, '0, '0));
    send_item(poll('0, 1'b1));
    send_item(poll('0, 1'b0));  // stamp all ones: elapsed wraps to one
    send_item(poll('1, 1'b0));
    settle();

    apb_write(REG_DELAY, 32'hFFFF);
    apb_write(REG_QSIZE, 32'd4);
    apb_write(REG_BP_EN, 32'd1);
    apb_write(REG_HIGH_WATER, 32'd0);
    apb_write(REG_LOW_WATER, 32'd1024);
    lim = 64'd65535 * 64'(NS_PER_MS);
    t0 = {$urandom, $urandom};
    repeat (4) send_item(enq($urandom, t0, 16'($urandom)));  // last one finds the ring full
    send_item(poll(t0, 1'b0));
    send_item(poll(t0 - 64'd1, 1'b0));  // now behind stamp
    send_item(poll(t0 + lim - 64'd1, 1'b0));
    send_item(poll(t0 + lim, 1'b0));
    send_item(enq($urandom, t0, 16'($urandom)));
    settle();
    apb_write(REG_QSIZE, 32'd6);  // not a power of two, ring kept
    send_item(poll(t0, 1'b0));
    settle();
    apb_write(REG_QSIZE, 32'd8);  // empties ring, head stays
    apb_write(REG_UNUSED, $urandom);
    send_item(poll(t0 + lim, 1'b0));
    send_item(poll(t0 + lim, 1'b0));
    settle();
    apb_write(REG_QSIZE, 32'd2052);  // upper bits dropped, lands on 4

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0:       dly = '0;
        1:       dly = '1;
        default: dly = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      endcase
      case (p)
        0:       qs = 11'd4;
        1:       qs = 11'd1024;
        2:       qs = 11'd8;
        3:       qs = 11'd16;
        4:       qs = 11'd4;
        default: qs = 11'(1 << $urandom_range(2, 10));
      endcase
      apb_write(REG_QSIZE, $urandom);  // usually ignored
      apb_write(REG_DELAY, 32'(dly));
      apb_write(REG_QSIZE, 32'(qs));
      apb_write(REG_BP_EN, (p % 4 == 3) ? 32'd0 : 32'($urandom_range(0, 1)) | 32'(p < 3));
      apb_write(REG_HIGH_WATER, (p == 2) ? 32'd1024 : (p == 3) ? 32'd0 :
                                32'($urandom_range(0, int'(qs) + 2)));
      apb_write(REG_LOW_WATER, (p == 2) ? 32'd0 : (p == 3) ? 32'd1024 :
                               32'($urandom_range(0, int'(qs) + 2)));
      lim = 64'(dly) * 64'(NS_PER_MS);
      clock_ns = {$urandom, $urandom};
      enq_pct = $urandom_range(25, 75);
      repeat (110) begin
        step = (lim == 0) ? 64'($urandom_range(0, 3)) :
               (lim / 64) * 64'($urandom_range(0, 16)) + 64'($urandom_range(0, 1));
        clock_ns = clock_ns + step;
        if ($urandom_range(0, 99) < enq_pct) begin
          stamp = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ns;
          send_item(enq($urandom, stamp, 16'($urandom)));
        end else begin
          pick = $urandom_range(0, 19);
          if (pick == 0) now = {$urandom, $urandom};
          else if (pick < 3) now = clock_ns - 64'($urandom_range(1, 1000));
          else now = clock_ns;
          send_item(poll(now, 1'($urandom_range(0, 99) < 15)));
        end
      end
    end

    settle();
    if (errors == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
